// File: design/u8d_pkg.sv
// u8d_pkg: types, tables and helper functions of the utf-8 code point decoder
// no dependencies; imported by the cells, the tail stage and the top level

package u8d_pkg;

  localparam int unsigned TransSize = 108;

  localparam logic [6:0]  DFA_ACCEPT = 7'd0;
  localparam logic [6:0]  DFA_REJECT = 7'd12;
  localparam logic [20:0] REPL_CHAR  = 21'h00FFFD;
  localparam logic [7:0]  LEAD_MASK  = 8'hFF;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_END      = 3'd1,
    ST_PREFIX   = 3'd2,
    ST_OVERLONG = 3'd3,
    ST_CONT     = 3'd4,
    ST_TRUNC    = 3'd5
  } status_e;

  localparam logic [6:0] TRANS_TAB [TransSize] = '{
    7'd0,  7'd12, 7'd24, 7'd36, 7'd60, 7'd96, 7'd84, 7'd12, 7'd12, 7'd12, 7'd48, 7'd72,
    7'd12, 7'd12, 7'd12, 7'd12, 7'd12, 7'd12, 7'd12, 7'd12, 7'd12, 7'd12, 7'd12, 7'd12,
    7'd12, 7'd0,  7'd12, 7'd12, 7'd12, 7'd12, 7'd12, 7'd0,  7'd12, 7'd0,  7'd12, 7'd12,
    7'd12, 7'd24, 7'd12, 7'd12, 7'd12, 7'd12, 7'd12, 7'd24, 7'd12, 7'd24, 7'd12, 7'd12,
    7'd12, 7'd12, 7'd12, 7'd12, 7'd12, 7'd12, 7'd12, 7'd24, 7'd12, 7'd12, 7'd12, 7'd12,
    7'd12, 7'd24, 7'd12, 7'd12, 7'd12, 7'd12, 7'd12, 7'd12, 7'd12, 7'd24, 7'd12, 7'd12,
    7'd12, 7'd12, 7'd12, 7'd12, 7'd12, 7'd12, 7'd12, 7'd36, 7'd12, 7'd36, 7'd12, 7'd12,
    7'd12, 7'd36, 7'd12, 7'd12, 7'd12, 7'd12, 7'd12, 7'd36, 7'd12, 7'd36, 7'd12, 7'd12,
    7'd12, 7'd36, 7'd12, 7'd12, 7'd12, 7'd12, 7'd12, 7'd36, 7'd12, 7'd36, 7'd12, 7'd12
  };

  typedef struct packed {
    logic            done;
    logic [20:0]     acc;
    logic [2:0]      used;
    status_e         st;
    logic [6:0]      dfa;
    logic [2:0]      pos;
    logic [3:0][7:0] win;
    logic [2:0]      avail;
    logic [7:0]      b1;
  } token_t;

  function automatic logic [3:0] byte_class(input logic [7:0] b);
    logic [3:0] cls;
    if (b < 8'h80)       cls = 4'd0;
    else if (b < 8'h90)  cls = 4'd1;
    else if (b < 8'hA0)  cls = 4'd9;
    else if (b < 8'hC0)  cls = 4'd7;
    else if (b < 8'hC2)  cls = 4'd8;
    else if (b < 8'hE0)  cls = 4'd2;
    else if (b == 8'hE0) cls = 4'd10;
    else if (b == 8'hED) cls = 4'd4;
    else if (b < 8'hF0)  cls = 4'd3;
    else if (b == 8'hF0) cls = 4'd11;
    else if (b < 8'hF4)  cls = 4'd6;
    else if (b == 8'hF4) cls = 4'd5;
    else                 cls = 4'd8;
    return cls;
  endfunction

  function automatic status_e diagnose(input logic [7:0] b0, input logic [7:0] b1);
    status_e st;
    if (b0 == 8'hED && b1 >= 8'hA0 && b1 <= 8'hBF)      st = ST_PREFIX;
    else if (b0 == 8'hF4 && b1 >= 8'h90 && b1 <= 8'hBF) st = ST_PREFIX;
    else if (b0 == 8'hE0 && b1 >= 8'h80 && b1 <= 8'h9F) st = ST_OVERLONG;
    else if (b0 == 8'hF0 && b1 >= 8'h80 && b1 <= 8'h8F) st = ST_OVERLONG;
    else if (b0 >= 8'h80 && b0 <= 8'hBF)                st = ST_PREFIX;
    else if (b0 >= 8'hF5)                               st = ST_PREFIX;
    else if (b0 == 8'hC0 || b0 == 8'hC1)                st = ST_OVERLONG;
    else                                                st = ST_CONT;
    return st;
  endfunction

  function automatic status_e strict_check(input logic [20:0] cp, input logic [2:0] len);
    status_e st;
    if (cp > 21'h10FFFF)                        st = ST_PREFIX;
    else if (cp >= 21'h00D800 && cp <= 21'h00DFFF) st = ST_PREFIX;
    else if (len == 3'd1 && cp >= 21'h000080)   st = ST_PREFIX;
    else if (len == 3'd2 && cp <= 21'h00007F)   st = ST_OVERLONG;
    else if (len == 3'd3 && cp <= 21'h0007FF)   st = ST_OVERLONG;
    else if (len == 3'd4 && cp <= 21'h00FFFF)   st = ST_OVERLONG;
    else                                        st = ST_OK;
    return st;
  endfunction

  function automatic logic [2:0] lead_length(input logic [7:0] b0);
    logic [2:0] n;
    if (b0 < 8'h80)                      n = 3'd1;
    else if (b0 >= 8'hC2 && b0 <= 8'hDF) n = 3'd2;
    else if (b0 >= 8'hE0 && b0 <= 8'hEF) n = 3'd3;
    else if (b0 >= 8'hF0 && b0 <= 8'hF4) n = 3'd4;
    else                                 n = 3'd0;
    return n;
  endfunction

endpackage

// File: design/u8d_in_if.sv
// u8d_in_if: input channel of the decoder, valid/ready plus a four-byte window
// no dependencies

interface u8d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] lead_byte;
  logic [7:0] follow_byte;
  logic [7:0] third_byte;
  logic [7:0] fourth_byte;
  logic [2:0] bytes_available;

  modport source (
    output valid, lead_byte, follow_byte, third_byte, fourth_byte, bytes_available,
    input  ready
  );
  modport sink (
    input  valid, lead_byte, follow_byte, third_byte, fourth_byte, bytes_available,
    output ready
  );
endinterface

// File: design/u8d_out_if.sv
// u8d_out_if: result channel of the decoder, valid/ready plus code point and status
// no dependencies

interface u8d_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic [2:0]  advance_len;
  logic [2:0]  status;

  modport source (
    output valid, code_point, advance_len, status,
    input  ready
  );
  modport sink (
    input  valid, code_point, advance_len, status,
    output ready
  );
endinterface

// File: design/u8d_cell.sv
// u8d_cell: one decode step, classifies one byte and advances the automaton
// depends on u8d_pkg; registered stage with its own valid/ready

module u8d_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  u8d_pkg::token_t tok_i,
  output logic            valid_o,
  input  logic            ready_i,
  output u8d_pkg::token_t tok_o
);
  import u8d_pkg::*;

  logic       valid_q;
  token_t     tok_q, tok_d;
  logic [7:0] b;
  logic [3:0] cls;
  logic [6:0] nxt;
  logic [2:0] len;
  logic [20:0] acc;
  status_e    chk;

  always_comb begin
    tok_d = tok_i;
    b     = tok_i.win[tok_i.pos[1:0]];
    cls   = byte_class(b);
    len   = tok_i.pos + 3'd1;
    nxt   = TRANS_TAB[tok_i.dfa + {3'b000, cls}];
    if (tok_i.dfa != DFA_ACCEPT) begin
      acc = {tok_i.acc[14:0], b[5:0]};
    end else begin
      acc = {13'd0, (LEAD_MASK >> cls) & b};
    end
    chk = strict_check(acc, len);
    if (!tok_i.done && tok_i.pos < tok_i.avail) begin
      tok_d.acc = acc;
      tok_d.dfa = nxt;
      tok_d.pos = len;
      if (nxt == DFA_ACCEPT) begin
        tok_d.done = 1'b1;
        if (chk != ST_OK) begin
          tok_d.acc  = REPL_CHAR;
          tok_d.used = 3'd1;
          tok_d.st   = chk;
        end else begin
          tok_d.used = len;
          tok_d.st   = ST_OK;
        end
      end else if (nxt == DFA_REJECT) begin
        tok_d.done = 1'b1;
        tok_d.acc  = REPL_CHAR;
        tok_d.used = 3'd1;
        tok_d.st   = diagnose(tok_i.win[0], tok_i.b1);
      end
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      tok_q <= tok_d;
    end
  end

  assign valid_o = valid_q;
  assign tok_o   = tok_q;
endmodule

// File: design/u8d_tail.sv
// u8d_tail: settles items that ran out of bytes and holds the result register
// depends on u8d_pkg and u8d_out_if

module u8d_tail (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  u8d_pkg::token_t tok_i,
  u8d_out_if.source       out_o
);
  import u8d_pkg::*;

  logic        valid_q;
  logic [20:0] cp_q, cp_d;
  logic [2:0]  used_q, used_d;
  status_e     st_q, st_d;
  logic [2:0]  need;

  always_comb begin
    need   = lead_length(tok_i.win[0]);
    cp_d   = tok_i.acc;
    used_d = tok_i.used;
    st_d   = tok_i.st;
    if (!tok_i.done) begin
      cp_d   = REPL_CHAR;
      used_d = 3'd1;
      if (need == 3'd0) begin
        st_d = diagnose(tok_i.win[0], tok_i.b1);
      end else if (tok_i.avail < need) begin
        st_d = ST_TRUNC;
      end else begin
        st_d = ST_PREFIX;
      end
    end
  end

  assign ready_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      cp_q   <= cp_d;
      used_q <= used_d;
      st_q   <= st_d;
    end
  end

  assign out_o.valid       = valid_q;
  assign out_o.code_point  = cp_q;
  assign out_o.advance_len = used_q;
  assign out_o.status      = st_q;
endmodule

// File: design/utf8_codepoint_decoder.sv
// utf8_codepoint_decoder: top level, a row of four decode cells and a result stage
// depends on u8d_pkg, u8d_in_if, u8d_out_if, u8d_cell and u8d_tail
//
// usage
// - in_i carries one item: a four-byte window and bytes_available (values above
//   four count as four); out_o returns one result item per input item, in order:
//   code point, bytes to advance and status
// - each cell takes one byte of the window and one automaton step; the last
//   stage settles windows that end inside a sequence and holds the result
// - each item is registered in the four cells and then in the result stage before
//   out_o.valid rises; one item per cycle while out_o.ready stays high
// - every stage has its own valid/ready, so a stalled receiver stops only the
//   stages behind a full one; bubbles in the row are filled while it waits
// - reset clears all stage valid flags; no item is in flight afterwards

module utf8_codepoint_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  u8d_in_if.sink     in_i,
  u8d_out_if.source  out_o
);
  import u8d_pkg::*;

  localparam int unsigned NumCells = 4;

  logic       [NumCells:0] valid;
  logic       [NumCells:0] ready;
  token_t                  tok [NumCells+1];
  token_t                  head_tok;
  logic       [2:0]        avail_sat;

  always_comb begin
    avail_sat = (in_i.bytes_available > 3'd4) ? 3'd4 : in_i.bytes_available;
    head_tok.done  = (avail_sat == 3'd0);
    head_tok.acc   = REPL_CHAR;
    head_tok.used  = 3'd0;
    head_tok.st    = ST_END;
    head_tok.dfa   = DFA_ACCEPT;
    head_tok.pos   = 3'd0;
    head_tok.win   = {in_i.fourth_byte, in_i.third_byte, in_i.follow_byte, in_i.lead_byte};
    head_tok.avail = avail_sat;
    head_tok.b1    = (avail_sat > 3'd1) ? in_i.follow_byte : 8'd0;
  end

  assign tok[0]     = head_tok;
  assign valid[0]   = in_i.valid;
  assign in_i.ready = ready[0];

  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    u8d_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid[k]),
      .ready_o (ready[k]),
      .tok_i   (tok[k]),
      .valid_o (valid[k+1]),
      .ready_i (ready[k+1]),
      .tok_o   (tok[k+1])
    );
  end

  u8d_tail u_tail (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid[NumCells]),
    .ready_o (ready[NumCells]),
    .tok_i   (tok[NumCells]),
    .out_o   (out_o)
  );
endmodule
